// ===== sv/nwed_pkg.sv =====
// Shared types, constants and cost helpers for the nearest-word edit distance block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package nwed_pkg;

    localparam int MAX_SOURCE_LEN = 32;
    localparam int LEN_W          = $clog2(MAX_SOURCE_LEN + 1);
    localparam int CHAR_W         = 8;
    localparam int COST_W         = 8;
    localparam int INDEX_W        = 16;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_CAND   = 2'd2,
        FUNC_EMPTY  = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [COST_W-1:0]  word_distance;
        logic [INDEX_W-1:0] word_index;
        logic [COST_W-1:0]  best_distance;
        logic [INDEX_W-1:0] best_index;
        logic               query_overflow;
    } result_t;

    // One candidate character travelling down the row of cells.
    typedef struct packed {
        logic              valid;
        logic              first;   // first character of a word: reload costs
        logic              last;
        logic [CHAR_W-1:0] ch;
        logic [COST_W-1:0] left;    // new cost of the sending cell
        logic [COST_W-1:0] diag;    // old cost of the sending cell
    } token_t;

    function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
        sat_inc = (v == COST_MAX) ? COST_MAX : v + COST_W'(1);
    endfunction

    function automatic logic [COST_W-1:0] min3(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b,
                                               input logic [COST_W-1:0] c);
        logic [COST_W-1:0] m;
        m    = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/nearest_word_edit_distance.sv =====
// Nearest-word search by edit distance over a systolic row of cells; uses nwed_pkg,
// nwed_head and nwed_cell.
// Empty word: result registered in the cycle after acceptance. Last-marked candidate:
// wave passes the head and q cell registers (q = query length; one cell/cycle), then the
// result is registered. Candidate characters go one per cycle unless stalled; after
// a last-marked one the input stalls until its result is registered. Reset clears
// all control state at once; query chars undefined until appended; no clearing pass.
`default_nettype none

module nearest_word_edit_distance (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire nwed_pkg::item_t item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output nwed_pkg::result_t    result
);

    // toks[k] is the registered token leaving column k (column 0 is the head)
    nwed_pkg::token_t toks [0:nwed_pkg::MAX_SOURCE_LEN];

    logic [nwed_pkg::LEN_W-1:0]   qlen_reg, qlen_next;
    logic                         ovf_reg, ovf_next;
    logic [nwed_pkg::COST_W-1:0]  best_cost_reg, best_cost_next;
    logic [nwed_pkg::INDEX_W-1:0] best_pos_reg, best_pos_next;
    logic [nwed_pkg::INDEX_W-1:0] words_reg, words_next;
    logic                         pending_reg, pending_next;
    logic                         res_valid_reg, res_valid_next;
    nwed_pkg::result_t            res_reg, res_next;

    logic                         accept;
    logic                         makes_result;
    logic                         q_wr;
    nwed_pkg::token_t             tap_tok;
    logic                         tap_hit;
    logic                         fire;
    logic [nwed_pkg::COST_W-1:0]  res_dist;
    logic                         better;

    // Which items end a word and therefore produce a transaction on the result side.
    always_comb
    begin
        case (item.func) inside
            nwed_pkg::FUNC_EMPTY: makes_result = 1'b1;
            nwed_pkg::FUNC_CAND:  makes_result = item.last;
            default:              makes_result = 1'b0;
        endcase
    end

    // Hold input while a word end is still travelling down the row, and hold any
    // result-producing item while the previous result is still unread.
    assign item_stall = pending_reg || (res_valid_reg && makes_result);
    assign accept     = item_valid && !item_stall;
    assign q_wr       = accept && (item.func == nwed_pkg::FUNC_APPEND)
                        && (qlen_reg < nwed_pkg::LEN_W'(nwed_pkg::MAX_SOURCE_LEN));

    nwed_head u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .tok_out (toks[0])
    );

    for (genvar i = 1; i <= nwed_pkg::MAX_SOURCE_LEN; i++)
    begin : g_cell
        nwed_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (nwed_pkg::COST_W'(i)),
            .q_we    (q_wr && (qlen_reg == nwed_pkg::LEN_W'(i - 1))),
            .q_ch    (item.ch),
            .tok_in  (toks[i-1]),
            .tok_out (toks[i])
        );
    end

    // The final cost of a word is read where the wave passes the last query column.
    assign tap_tok = toks[qlen_reg];
    assign tap_hit = tap_tok.valid && tap_tok.last;

    assign fire     = tap_hit || (accept && (item.func == nwed_pkg::FUNC_EMPTY));
    assign res_dist = tap_hit ? tap_tok.left : nwed_pkg::COST_W'(qlen_reg);
    assign better   = res_dist < best_cost_reg;

    always_comb
    begin
        qlen_next      = qlen_reg;
        ovf_next       = ovf_reg;
        best_cost_next = best_cost_reg;
        best_pos_next  = best_pos_reg;
        words_next     = words_reg;
        pending_next   = pending_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;

        if (accept)
        begin
            case (item.func)
                nwed_pkg::FUNC_CLEAR:
                begin
                    qlen_next      = '0;
                    ovf_next       = 1'b0;
                    best_cost_next = nwed_pkg::COST_MAX;
                    best_pos_next  = '0;
                    words_next     = '0;
                end
                nwed_pkg::FUNC_APPEND:
                begin
                    if (q_wr)
                        qlen_next = qlen_reg + nwed_pkg::LEN_W'(1);
                    else
                        ovf_next = 1'b1;
                end
                nwed_pkg::FUNC_CAND:
                begin
                    pending_next = item.last;
                end
                default:
                begin
                end
            endcase
        end

        if (fire)
        begin
            // Strict less-than keeps the first word at the minimum.
            if (better)
            begin
                best_cost_next = res_dist;
                best_pos_next  = words_reg;
            end
            words_next              = words_reg + nwed_pkg::INDEX_W'(1);
            pending_next            = 1'b0;
            res_valid_next          = 1'b1;
            res_next.word_distance  = res_dist;
            res_next.word_index     = words_reg;
            res_next.best_distance  = better ? res_dist : best_cost_reg;
            res_next.best_index     = better ? words_reg : best_pos_reg;
            res_next.query_overflow = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            best_cost_reg <= nwed_pkg::COST_MAX;
            best_pos_reg  <= '0;
            words_reg     <= '0;
            pending_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            qlen_reg      <= qlen_next;
            ovf_reg       <= ovf_next;
            best_cost_reg <= best_cost_next;
            best_pos_reg  <= best_pos_next;
            words_reg     <= words_next;
            pending_reg   <= pending_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // A word end reaching the tap must find the output register free.
    a_tap_free: assert property (@(posedge clk) disable iff (!rst_n)
        tap_hit |-> !res_valid_reg)
        else $error("word end reached tap while result register full");

    // A word end only reaches the tap while one is outstanding.
    a_tap_pending: assert property (@(posedge clk) disable iff (!rst_n)
        tap_hit |-> pending_reg)
        else $error("unexpected word end at tap");

    // Query length never exceeds capacity.
    a_qlen_range: assert property (@(posedge clk) disable iff (!rst_n)
        qlen_reg <= nwed_pkg::LEN_W'(nwed_pkg::MAX_SOURCE_LEN))
        else $error("query length beyond capacity");

    // The best distance never grows except through a clear.
    a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && item.func == nwed_pkg::FUNC_CLEAR) |=>
            best_cost_reg <= $past(best_cost_reg))
        else $error("best distance increased without clear");

endmodule

`default_nettype wire

// ===== sv/nwed_head.sv =====
// Column zero of the cost row and the word-open tracker; launches tokens into the cells.
// Depends on nwed_pkg.
`default_nettype none

module nwed_head (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire nwed_pkg::item_t item,
    output nwed_pkg::token_t    tok_out
);

    logic                        word_open_reg, word_open_next;
    logic                        vld_reg;
    logic [nwed_pkg::COST_W-1:0] row0_reg, row0_next;
    logic [nwed_pkg::COST_W-1:0] old0;
    nwed_pkg::token_t            pl_reg, pl_next;
    logic                        launch;

    assign launch = accept && (item.func == nwed_pkg::FUNC_CAND);
    assign old0   = word_open_reg ? row0_reg : '0;

    always_comb
    begin
        word_open_next = word_open_reg;
        if (accept)
        begin
            case (item.func)
                nwed_pkg::FUNC_CAND: word_open_next = !item.last;
                default:             word_open_next = 1'b0;
            endcase
        end
        row0_next     = launch ? nwed_pkg::sat_inc(old0) : row0_reg;
        pl_next.valid = 1'b0;
        pl_next.first = !word_open_reg;
        pl_next.last  = item.last;
        pl_next.ch    = item.ch;
        pl_next.left  = nwed_pkg::sat_inc(old0);
        pl_next.diag  = old0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_open_reg <= 1'b0;
            vld_reg       <= 1'b0;
        end
        else
        begin
            word_open_reg <= word_open_next;
            vld_reg       <= launch;
        end
    end

    always_ff @(posedge clk)
    begin
        row0_reg <= row0_next;
        pl_reg   <= pl_next;
    end

    always_comb
    begin
        tok_out       = pl_reg;
        tok_out.valid = vld_reg;
    end

endmodule

`default_nettype wire

// ===== sv/nwed_cell.sv =====
// One query position: its character and its cost, updated as a token passes.
// Depends on nwed_pkg.
`default_nettype none

module nwed_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [nwed_pkg::COST_W-1:0] idx,
    input  wire logic                        q_we,
    input  wire logic [nwed_pkg::CHAR_W-1:0] q_ch,
    input  wire nwed_pkg::token_t            tok_in,
    output nwed_pkg::token_t                 tok_out
);

    logic [nwed_pkg::CHAR_W-1:0] qch_reg;
    logic [nwed_pkg::COST_W-1:0] cost_reg, cost_next;
    logic [nwed_pkg::COST_W-1:0] above, upd;
    logic                        vld_reg;
    nwed_pkg::token_t            pl_reg, pl_next;

    assign above = tok_in.first ? idx : cost_reg;

    always_comb
    begin
        if (qch_reg == tok_in.ch)
            upd = tok_in.diag;
        else
            upd = nwed_pkg::sat_inc(nwed_pkg::min3(tok_in.left, above, tok_in.diag));
        cost_next     = tok_in.valid ? upd : cost_reg;
        pl_next       = tok_in;
        pl_next.left  = upd;
        pl_next.diag  = above;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= tok_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            qch_reg <= q_ch;
        cost_reg <= cost_next;
        pl_reg   <= pl_next;
    end

    always_comb
    begin
        tok_out       = pl_reg;
        tok_out.valid = vld_reg;
    end

endmodule

`default_nettype wire

// ===== sim/nearest_word_edit_distance_tb.sv =====
// Self-checking testbench for nearest_word_edit_distance: drives query and candidate
// transactions and compares each word report with an edit-distance scoreboard.
// Depends on nwed_pkg for the transaction types and on the block's RTL.
module nearest_word_edit_distance_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Predicts one word report per word end and checks reports in order.
    class nearest_word_scoreboard;
        logic [nwed_pkg::CHAR_W-1:0]  query_text [nwed_pkg::MAX_SOURCE_LEN];
        int unsigned                  query_len;
        logic [nwed_pkg::COST_W-1:0]  cost_row [nwed_pkg::MAX_SOURCE_LEN+1];
        bit                           word_active;
        logic [nwed_pkg::COST_W-1:0]  best_cost;
        logic [nwed_pkg::INDEX_W-1:0] best_word;
        logic [nwed_pkg::INDEX_W-1:0] word_count;
        bit                           overflowed;
        nwed_pkg::result_t            expected_reports [$];
        int unsigned                  mismatches;

        function new();
            mismatches = 0;
            restart_search();
        endfunction

        function logic [nwed_pkg::COST_W-1:0] bump(input logic [nwed_pkg::COST_W-1:0] v);
            return (v == {nwed_pkg::COST_W{1'b1}}) ? v : v + 1'b1;
        endfunction

        function void reload_row();
            for (int i = 0; i <= nwed_pkg::MAX_SOURCE_LEN; i++)
                cost_row[i] = (i > 255) ? 8'hFF : nwed_pkg::COST_W'(i);
        endfunction

        function void restart_search();
            foreach (query_text[i]) query_text[i] = '0;
            query_len   = 0;
            reload_row();
            word_active = 0;
            best_cost   = {nwed_pkg::COST_W{1'b1}};
            best_word   = '0;
            word_count  = '0;
            overflowed  = 0;
        endfunction

        // Push one candidate character through the row of costs.
        function void step_row(input logic [nwed_pkg::CHAR_W-1:0] c);
            logic [nwed_pkg::COST_W-1:0] diag;
            logic [nwed_pkg::COST_W-1:0] above;
            logic [nwed_pkg::COST_W-1:0] low;
            diag        = cost_row[0];
            cost_row[0] = bump(cost_row[0]);
            for (int i = 1; i <= query_len; i++)
            begin
                above = cost_row[i];
                if (query_text[i-1] == c)
                begin
                    cost_row[i] = diag;
                end
                else
                begin
                    low = cost_row[i-1];
                    if (above < low) low = above;
                    if (diag < low) low = diag;
                    cost_row[i] = bump(low);
                end
                diag = above;
            end
        endfunction

        function void close_word(input logic [nwed_pkg::COST_W-1:0] word_cost);
            nwed_pkg::result_t r;
            if (word_cost < best_cost)
            begin
                best_cost = word_cost;
                best_word = word_count;
            end
            r.word_distance  = word_cost;
            r.word_index     = word_count;
            r.best_distance  = best_cost;
            r.best_index     = best_word;
            r.query_overflow = overflowed;
            expected_reports = {expected_reports, r};
            word_count  = word_count + 1'b1;
            word_active = 0;
        endfunction

        // Note one accepted input transaction.
        function void record_item(input nwed_pkg::item_t it);
            case (it.func)
                nwed_pkg::FUNC_CLEAR: restart_search();
                nwed_pkg::FUNC_APPEND:
                begin
                    word_active = 0;
                    if (query_len < nwed_pkg::MAX_SOURCE_LEN)
                    begin
                        query_text[query_len] = it.ch;
                        query_len++;
                    end
                    else
                    begin
                        overflowed = 1;
                    end
                end
                nwed_pkg::FUNC_CAND:
                begin
                    if (!word_active)
                    begin
                        reload_row();
                        word_active = 1;
                    end
                    step_row(it.ch);
                    if (it.last) close_word(cost_row[query_len]);
                end
                default:
                begin
                    word_active = 0;
                    close_word((query_len > 255) ? 8'hFF : nwed_pkg::COST_W'(query_len));
                end
            endcase
        endfunction

        task report_mismatch(input string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Compare one accepted result transaction with the oldest prediction.
        task check_result(input nwed_pkg::result_t got);
            nwed_pkg::result_t want;
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending (word_index %0d)",
                                          got.word_index));
                return;
            end
            want = expected_reports.pop_front();
            if (got.word_distance !== want.word_distance)
                report_mismatch($sformatf("word %0d: word_distance %0d, expected %0d",
                                          want.word_index, got.word_distance,
                                          want.word_distance));
            if (got.word_index !== want.word_index)
                report_mismatch($sformatf("word_index %0d, expected %0d",
                                          got.word_index, want.word_index));
            if (got.best_distance !== want.best_distance)
                report_mismatch($sformatf("word %0d: best_distance %0d, expected %0d",
                                          want.word_index, got.best_distance,
                                          want.best_distance));
            if (got.best_index !== want.best_index)
                report_mismatch($sformatf("word %0d: best_index %0d, expected %0d",
                                          want.word_index, got.best_index,
                                          want.best_index));
            if (got.query_overflow !== want.query_overflow)
                report_mismatch($sformatf("word %0d: query_overflow %0b, expected %0b",
                                          want.word_index, got.query_overflow,
                                          want.query_overflow));
        endtask

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    localparam int ITEM_COUNT  = 1300;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = nwed_pkg::MAX_SOURCE_LEN + 8;   // longest wavefront plus margin

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    nwed_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    nwed_pkg::result_t result;

    nearest_word_scoreboard sb;

    // Sender pacing and the hand-off to the receiver for long hold-offs.
    int          burst_left    = 0;
    bit          steady_sender = 0;
    int          holds_asked   = 0;
    int          holds_done    = 0;
    int unsigned items_sent    = 0;

    // Shadow of the query so candidates can be built close to it.
    logic [nwed_pkg::CHAR_W-1:0] query_shadow [$];

    nearest_word_edit_distance DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Monitor both channels at the clock edge. Inputs are noted before results so a
    // prediction is always queued before its report could be checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall) sb.record_item(item);
            if (result_valid && !result_stall) sb.check_result(result);
        end
    end

    // Receiver: stall in segments of random style; serve long hold-off requests by
    // counting cycles here, independent of the sender.
    initial
    begin : receiver
        int  style;
        int  seg_len;
        bit  phase;
        phase = 0;
        forever
        begin
            if (holds_done != holds_asked)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                style   = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 60);
                repeat (seg_len)
                begin
                    if (holds_done != holds_asked)
                        break;
                    case (style)
                        0:       result_stall <= 1'b0;
                        1:       result_stall <= ($urandom_range(0, 3) == 0);
                        2:       result_stall <= 1'($urandom_range(0, 1));
                        default: result_stall <= phase;
                    endcase
                    phase = ~phase;
                    @(posedge clk);
                end
            end
        end
    end

    // Offer one transaction and hold it until accepted. Between bursts, drop valid
    // for a random gap unless the sender is held steady.
    task automatic put_item(input nwed_pkg::func_t f, input logic [nwed_pkg::CHAR_W-1:0] c,
                            input logic l);
        int gap;
        if (!steady_sender && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0) burst_left--;
        item_valid <= 1'b1;
        item       <= '{func: f, ch: c, last: l};
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic clear_query(input logic l);
        put_item(nwed_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), l);
        query_shadow.delete();
    endtask

    task automatic append_char(input logic [nwed_pkg::CHAR_W-1:0] c);
        put_item(nwed_pkg::FUNC_APPEND, c, 1'($urandom_range(0, 1)));
        if (query_shadow.size() < nwed_pkg::MAX_SOURCE_LEN) query_shadow = {query_shadow, c};
    endtask

    // Pause the sender until every predicted report has arrived, then let the row
    // settle for the longest wavefront.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [nwed_pkg::CHAR_W-1:0] pick_char(input bit narrow);
        return narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    endfunction

    // One search round: maybe clear, grow the query, then stream a few words.
    // Most words are well formed and built from the query; a few are broken off.
    task automatic random_round();
        int  qn;
        int  nwords;
        int  kind;
        int  wl;
        bit  narrow;
        logic [nwed_pkg::CHAR_W-1:0] c;
        narrow = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1) == 0)
        begin
            clear_query(1'($urandom_range(0, 1)));
            kind = $urandom_range(0, 9);
            if (kind < 7)      qn = $urandom_range(0, 6);
            else if (kind < 9) qn = $urandom_range(7, 20);
            else               qn = $urandom_range(28, 40);
        end
        else
        begin
            qn = $urandom_range(0, 2);
        end
        repeat (qn) append_char(pick_char(narrow));

        nwords = $urandom_range(1, 6);
        repeat (nwords)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                put_item(nwed_pkg::FUNC_EMPTY, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end
            else if (kind == 1)
            begin
                // Break a word off part way.
                repeat ($urandom_range(1, 4))
                    put_item(nwed_pkg::FUNC_CAND, pick_char(narrow), 1'b0);
                case ($urandom_range(0, 2))
                    0:       append_char(pick_char(narrow));
                    1:       put_item(nwed_pkg::FUNC_EMPTY, pick_char(narrow),
                                      1'($urandom_range(0, 1)));
                    default: clear_query(1'($urandom_range(0, 1)));
                endcase
            end
            else
            begin
                wl = $urandom_range(1, query_shadow.size() + 3);
                for (int j = 0; j < wl; j++)
                begin
                    if (kind < 14 && j < query_shadow.size() && $urandom_range(0, 3) != 0)
                        c = query_shadow[j];
                    else
                        c = pick_char(narrow);
                    put_item(nwed_pkg::FUNC_CAND, c, j == wl - 1);
                end
            end
        end
    endtask

    initial
    begin : timeout
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty query, character extremes, abandoned words, ignored last
        // marks, and a clear in the middle of a word.
        clear_query(1'b1);
        put_item(nwed_pkg::FUNC_EMPTY, 8'hFF, 1'b1);
        put_item(nwed_pkg::FUNC_CAND, 8'h00, 1'b1);
        append_char(8'h00);
        append_char(8'hFF);
        append_char(8'h80);
        put_item(nwed_pkg::FUNC_CAND, 8'h00, 1'b0);
        put_item(nwed_pkg::FUNC_CAND, 8'hFF, 1'b0);
        put_item(nwed_pkg::FUNC_CAND, 8'h80, 1'b1);
        put_item(nwed_pkg::FUNC_CAND, 8'h00, 1'b0);
        append_char(8'h7F);
        put_item(nwed_pkg::FUNC_CAND, 8'h7F, 1'b1);
        put_item(nwed_pkg::FUNC_EMPTY, 8'h00, 1'b0);
        put_item(nwed_pkg::FUNC_CAND, 8'h01, 1'b0);
        put_item(nwed_pkg::FUNC_EMPTY, 8'h01, 1'b1);
        put_item(nwed_pkg::FUNC_CAND, 8'hFE, 1'b1);
        put_item(nwed_pkg::FUNC_CAND, 8'h55, 1'b0);
        clear_query(1'b0);
        put_item(nwed_pkg::FUNC_CAND, 8'hAA, 1'b1);
        append_char(8'h5A);
        put_item(nwed_pkg::FUNC_CAND, 8'h5A, 1'b1);

        // Saturation: a long word against an empty query never beats the initial
        // best; then fill the query past capacity and find an exact match.
        clear_query(1'b0);
        for (int j = 0; j < 300; j++) put_item(nwed_pkg::FUNC_CAND, 8'h41, j == 299);
        repeat (nwed_pkg::MAX_SOURCE_LEN + 2) append_char(8'h78);
        for (int j = 0; j < 300; j++) put_item(nwed_pkg::FUNC_CAND, 8'h79, j == 299);
        for (int j = 0; j < nwed_pkg::MAX_SOURCE_LEN; j++)
            put_item(nwed_pkg::FUNC_CAND, 8'h78, j == nwed_pkg::MAX_SOURCE_LEN - 1);
        put_item(nwed_pkg::FUNC_EMPTY, 8'h00, 1'b0);

        // Back-pressure: ask the receiver for a long hold-off and keep offering
        // transactions back to back so the block fills and stalls its input.
        holds_asked   <= holds_asked + 1;
        steady_sender = 1;
        repeat (8) random_round();
        steady_sender = 0;
        wait_for_results();

        // Random rounds up to the overall transaction count.
        while (items_sent < ITEM_COUNT) random_round();

        wait_for_results();
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== nearest_word_edit_distance.f =====
sv/nwed_pkg.sv
sv/nwed_head.sv
sv/nwed_cell.sv
sv/nearest_word_edit_distance.sv
sim/nearest_word_edit_distance_tb.sv
